>>> rtl/pts_pkg.sv
// Package for the prime table sieve query core: widths, opcodes, status codes
// and the command/status structs between controller and datapath. No dependencies.
package pts_pkg;
   localparam int MAX_LIMIT_DEF  = 65536;
   localparam int LIST_DEPTH_DEF = 8192;
   localparam int VALUE_W  = 32;
   localparam int BOUND_W  = 17;
   localparam int INDEX_W  = 14;
   localparam int PRIME_W  = 17;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [OPCODE_W-1:0] OP_BUILD = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PRIME = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_BEFORE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_AFTER = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DIV = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

   // Register byte address on the configuration port.
   localparam logic [1:0] REG_SIEVE_LIMIT = 2'd0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request fields
      logic clr_sweep;   // clear bitmap and struck entries at the sweep counter
      logic sieve_step;  // one step of the sieve scan
      logic strike_step; // strike one multiple
      logic bs_step;     // one binary-search step
      logic div_fetch;   // read the next listed prime
      logic div_start;   // start a remainder computation
      logic div_iter;    // one bit of the remainder
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic sieve_done;
      logic sieve_found;   // current candidate is prime, within the limit and the list has room
      logic strike_done;
      logic bs_done;
      logic rem_done;
   } stat_type;
endpackage

>>> rtl/prime_table_sieve_query_core.sv
// Top level of the prime table sieve query core: stream channels, register port,
// controller and datapath. Uses pts_pkg, pts_controller and pts_datapath.
//
//   Channel   Direction  Payload
//   req_      in         tdata = {divisor_bound, value, opcode}
//   rsp_      out        tdata = {status, largest_prime, prime_count, prime_index, flag}
//   csr_      in/out     APB-style, register 0 sieve_limit
//
// A build runs a clearing sweep, then a registered struck read and a sieve step for
// each candidate, and strikes the multiples of each prime found. A divisible test
// computes a bit-serial remainder for each prime walked; the other queries use a
// bitmap read or a binary search over the list. One transaction is in work at a time;
// a waiting result stalls the next request.
// Reset is synchronous; tables are undefined until the first build.
module prime_table_sieve_query_core #(
   parameter int MAX_LIMIT  = pts_pkg::MAX_LIMIT_DEF,
   parameter int LIST_DEPTH = pts_pkg::LIST_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // opcode[2:0], value[34:3], divisor_bound[51:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // flag[0], prime_index[14:1], prime_count[28:15],
                                    // largest_prime[45:29], status[47:46]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pts_pkg::*;
   localparam int NW = $clog2(MAX_LIMIT + 1) + 1;
   localparam int LW = $clog2(LIST_DEPTH + 1);

   cmd_type cmd;
   stat_type stat;
   logic [16:0] limit_ff;
   logic build_done, bitmap_bit, built, rem_zero;
   logic [VALUE_W-1:0] value_q;
   logic [BOUND_W-1:0] bound_q;
   logic [OPCODE_W-1:0] opcode_q;
   logic [LW-1:0] count_found, bs_lo, div_k;
   logic [NW-1:0] top_prime, div_p;
   logic res_flag;
   logic [INDEX_W-1:0] res_index;
   logic [STATUS_W-1:0] res_status;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 17'd65536;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_SIEVE_LIMIT)
         limit_ff <= csr_pwdata[16:0];
   end
   assign csr_prdata = (csr_paddr == REG_SIEVE_LIMIT) ? {15'd0, limit_ff} : 32'd0;

   pts_datapath #(.MAX_LIMIT(MAX_LIMIT), .LIST_DEPTH(LIST_DEPTH)) u_dp (
      .clock, .reset, .cmd, .stat,
      .opcode(req_tdata[2:0]), .value(req_tdata[34:3]), .divisor_bound(req_tdata[51:35]),
      .sieve_limit(limit_ff), .build_done, .value_q, .bound_q, .opcode_q, .bitmap_bit,
      .count_found, .top_prime, .built, .bs_lo, .div_k, .div_p, .rem_zero
   );

   pts_controller #(.LIST_DEPTH(LIST_DEPTH)) u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .cmd, .stat,
      .build_done, .opcode_q, .value_q, .bound_q, .bitmap_bit, .built, .count_found,
      .bs_lo, .div_k, .div_p(17'(div_p)), .top_prime(17'(top_prime)),
      .rem_zero, .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res_flag, .res_index,
      .res_status
   );

   assign rsp_tdata = {res_status, 17'(top_prime), INDEX_W'(count_found), res_index, res_flag};
endmodule

>>> rtl/pts_datapath.sv
// Datapath of the prime table sieve query core: bitmap, struck and list memories,
// sieve counters, binary search and a bit-serial remainder unit. Uses pts_pkg.
module pts_datapath #(
   parameter int MAX_LIMIT  = pts_pkg::MAX_LIMIT_DEF,
   parameter int LIST_DEPTH = pts_pkg::LIST_DEPTH_DEF,
   localparam int NW = $clog2(MAX_LIMIT + 1) + 1,
   localparam int LW = $clog2(LIST_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pts_pkg::cmd_type                  cmd,
   output pts_pkg::stat_type                 stat,
   input  logic [pts_pkg::OPCODE_W-1:0]      opcode,
   input  logic [pts_pkg::VALUE_W-1:0]       value,
   input  logic [pts_pkg::BOUND_W-1:0]       divisor_bound,
   input  logic [16:0]                       sieve_limit,
   input  logic                              build_done,
   output logic [pts_pkg::VALUE_W-1:0]       value_q,
   output logic [pts_pkg::BOUND_W-1:0]       bound_q,
   output logic [pts_pkg::OPCODE_W-1:0]      opcode_q,
   output logic                              bitmap_bit,
   output logic [LW-1:0]                     count_found,
   output logic [NW-1:0]                     top_prime,
   output logic                              built,
   output logic [LW-1:0]                     bs_lo,
   output logic [LW-1:0]                     div_k,
   output logic [NW-1:0]                     div_p,
   output logic                              rem_zero
);
   import pts_pkg::*;
   localparam int AW = $clog2(MAX_LIMIT + 1);
   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   logic bitmap_mem [MAX_LIMIT+1];
   logic struck_mem [MAX_LIMIT+1];
   logic [NW-1:0] list_mem [LIST_DEPTH];

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [BOUND_W-1:0] bound_ff;
   logic [OPCODE_W-1:0] op_ff;
   logic [NW-1:0] lim_ff, sweep_ff, cand_ff, mult_ff, stride_ff;
   logic [LW-1:0] count_ff, lo_ff, hi_ff, k_ff;
   logic [NW-1:0] top_ff, p_ff;
   logic built_ff;
   logic bit_rd_ff, struck_rd_ff;
   logic [NW-1:0] list_rd_ff;
   logic [VALUE_W:0] rem_ff;
   logic [5:0] rbit_ff;
   logic [LW-1:0] mid;
   logic [NW-1:0] lim_sat;
   logic bs_phase_ff;
   logic [LW-1:0] mid_ff;

   assign lim_sat = (sieve_limit < 17'd2) ? NW'(2) :
                    (NW'(sieve_limit) > NW'(MAX_LIMIT)) ? NW'(MAX_LIMIT) :
                    NW'(sieve_limit);
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Bitmap read for queries; struck read at the candidate, registered, so the
   // controller waits in S_SREAD after the candidate moves.
   always_ff @(posedge clock) begin
      if (cmd.clr_sweep) begin
         bitmap_mem[sweep_ff[AW-1:0]] <= 1'b0;
         struck_mem[sweep_ff[AW-1:0]] <= 1'b0;
      end else if (cmd.strike_step) begin
         struck_mem[mult_ff[AW-1:0]] <= 1'b1;
      end else if (cmd.sieve_step && stat.sieve_found) begin
         bitmap_mem[cand_ff[AW-1:0]] <= 1'b1;
         list_mem[count_ff[IW-1:0]] <= cand_ff;
      end
      bit_rd_ff <= (value_ff <= VALUE_W'(top_ff)) ? bitmap_mem[value_ff[AW-1:0]] : 1'b0;
      struck_rd_ff <= struck_mem[cand_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.bs_step) list_rd_ff <= list_mem[mid[IW-1:0]];
      else list_rd_ff <= list_mem[k_ff[IW-1:0]];
   end

   assign value_in = cmd.load ? value : value_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (cmd.load) begin
         bound_ff <= divisor_bound;
         op_ff    <= opcode;
         lim_ff   <= lim_sat;
         sweep_ff <= '0;
         cand_ff  <= NW'(2);
         lo_ff    <= '0;
         hi_ff    <= '0;
         k_ff     <= '0;
      end
      if (cmd.clr_sweep) sweep_ff <= sweep_ff + 1'b1;
      if (cmd.sieve_step) begin
         if (stat.sieve_found) begin
            mult_ff   <= cand_ff + cand_ff;
            stride_ff <= cand_ff;
         end
         cand_ff <= cand_ff + 1'b1;
      end
      if (cmd.strike_step) mult_ff <= mult_ff + stride_ff;
      // Binary search: the list read registered at mid is compared in the next step.
      if (cmd.bs_step) begin
         if (lo_ff == '0 && hi_ff == '0) hi_ff <= count_ff;
         else if (bs_phase_ff) begin
            if (VALUE_W'(list_rd_ff) <= value_ff) lo_ff <= mid_ff;
            else hi_ff <= mid_ff;
         end
      end
      if (cmd.div_fetch) p_ff <= list_rd_ff;
      if (cmd.div_start) begin
         rem_ff  <= '0;
         rbit_ff <= 6'(VALUE_W);
         k_ff    <= k_ff + 1'b1;
      end
      if (cmd.div_iter) begin
         // Restoring remainder, one dividend bit a cycle.
         logic [VALUE_W:0] sh;
         sh = {rem_ff[VALUE_W-1:0], value_ff[rbit_ff[4:0] - 5'd1]};
         rem_ff  <= (sh >= (VALUE_W+1)'(p_ff)) ? sh - (VALUE_W+1)'(p_ff) : sh;
         rbit_ff <= rbit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         bs_phase_ff <= 1'b0;
      end else if (cmd.bs_step) begin
         if (!bs_phase_ff) begin
            mid_ff <= mid;
            bs_phase_ff <= (hi_ff - lo_ff > LW'(1)) ? 1'b1 : 1'b0;
         end else begin
            bs_phase_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         top_ff   <= '0;
         built_ff <= 1'b0;
      end else begin
         if (cmd.load && opcode == OP_BUILD) begin
            count_ff <= '0;
            top_ff   <= '0;
         end
         if (cmd.sieve_step && stat.sieve_found) begin
            count_ff <= count_ff + 1'b1;
            top_ff   <= cand_ff;
         end
         if (build_done) built_ff <= 1'b1;
      end
   end

   assign stat.sweep_done  = (sweep_ff == lim_ff);
   assign stat.sieve_found = !struck_rd_ff && count_ff < LW'(LIST_DEPTH) && cand_ff <= lim_ff;
   assign stat.sieve_done  = (cand_ff > lim_ff) ||
                             (!struck_rd_ff && count_ff >= LW'(LIST_DEPTH));
   assign stat.strike_done = (mult_ff > lim_ff);
   assign stat.bs_done     = !bs_phase_ff && (hi_ff - lo_ff <= LW'(1)) &&
                             !(lo_ff == '0 && hi_ff == '0);
   assign stat.rem_done    = (rbit_ff == '0);

   assign value_q     = value_ff;
   assign bound_q     = bound_ff;
   assign opcode_q    = op_ff;
   assign bitmap_bit  = bit_rd_ff;
   assign count_found = count_ff;
   assign top_prime   = top_ff;
   assign built       = built_ff;
   assign bs_lo       = lo_ff;
   assign div_k       = k_ff;
   assign div_p       = p_ff;
   assign rem_zero    = (rem_ff == '0);
endmodule

>>> rtl/pts_controller.sv
// Controller of the prime table sieve query core: sequences build, search and
// trial division over the datapath. Uses pts_pkg.
module pts_controller #(
   parameter int LIST_DEPTH = pts_pkg::LIST_DEPTH_DEF,
   localparam int LW = $clog2(LIST_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   output pts_pkg::cmd_type              cmd,
   input  pts_pkg::stat_type             stat,
   output logic                          build_done,
   input  logic [pts_pkg::OPCODE_W-1:0]  opcode_q,
   input  logic [pts_pkg::VALUE_W-1:0]   value_q,
   input  logic [pts_pkg::BOUND_W-1:0]   bound_q,
   input  logic                          bitmap_bit,
   input  logic                          built,
   input  logic [LW-1:0]                 count_found,
   input  logic [LW-1:0]                 bs_lo,
   input  logic [LW-1:0]                 div_k,
   input  logic [16:0]                   div_p,
   input  logic [16:0]                   top_prime,
   input  logic                          rem_zero,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic                          res_flag,
   output logic [pts_pkg::INDEX_W-1:0]   res_index,
   output logic [pts_pkg::STATUS_W-1:0]  res_status
);
   import pts_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_DECODE = 4'd1, S_CLEAR = 4'd2, S_SIEVE = 4'd3,
      S_STRIKE = 4'd4, S_BITMAP = 4'd5, S_BS = 4'd6, S_DFETCH = 4'd7, S_DLOAD = 4'd8,
      S_DREM = 4'd9, S_DCHECK = 4'd10, S_DONE = 4'd11, S_DPRE = 4'd12, S_SREAD = 4'd13,
      S_DBIT = 4'd14, S_PBIT = 4'd15;
   logic [3:0] state_ff, state_in;
   logic flag_ff, flag_in, valid_ff, valid_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [33:0] psq;

   assign psq = 34'(div_p) * 34'(div_p);
   assign req_tready = (state_ff == S_IDLE) && !valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      build_done = 1'b0;
      flag_in = flag_ff; idx_in = idx_ff; st_in = st_ff; valid_in = valid_ff;
      if (valid_ff && res_ready) valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               flag_in = 1'b0; idx_in = '0; st_in = ST_OK;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (opcode_q == OP_BUILD) begin
               state_in = S_CLEAR;
            end else if (opcode_q > OP_DIV) begin
               state_in = S_DONE;
            end else if (!built) begin
               st_in = ST_NOT_BUILT; state_in = S_DONE;
            end else if (opcode_q == OP_DIV) begin
               state_in = S_DPRE;
            end else if (value_q > 32'(top_prime)) begin
               st_in = ST_ABOVE; state_in = S_DONE;
            end else if (opcode_q == OP_PRIME) begin
               state_in = S_BITMAP;
            end else if (value_q <= 32'd2) begin
               idx_in = (opcode_q == OP_AFTER) ? INDEX_W'(1) : '0;
               state_in = S_DONE;
            end else begin
               state_in = S_BS;
            end
         end
         S_CLEAR: begin
            cmd.clr_sweep = 1'b1;
            if (stat.sweep_done) state_in = S_SREAD;
         end
         S_SREAD: begin
            // The struck entry of the new candidate is read in this cycle.
            state_in = S_SIEVE;
         end
         S_SIEVE: begin
            if (stat.sieve_done) begin
               build_done = 1'b1; state_in = S_DONE;
            end else begin
               cmd.sieve_step = 1'b1;
               if (stat.sieve_found) state_in = S_STRIKE;
               else state_in = S_SREAD;
            end
         end
         S_STRIKE: begin
            if (stat.strike_done) state_in = S_SREAD;
            else cmd.strike_step = 1'b1;
         end
         S_BITMAP: begin
            state_in = S_PBIT; // wait for registered read
         end
         S_PBIT: begin
            // Registered bitmap read is now available for the prime test.
            flag_in = bitmap_bit; state_in = S_DONE;
         end
         S_BS: begin
            if (stat.bs_done) begin
               idx_in = INDEX_W'(bs_lo) + ((opcode_q == OP_AFTER) ? INDEX_W'(1) : '0);
               state_in = S_DONE;
            end else begin
               cmd.bs_step = 1'b1;
            end
         end
         S_DPRE: begin
            // Value that is itself a listed prime gives flag 0.
            state_in = S_DBIT;
         end
         S_DBIT: begin
            if (bitmap_bit) state_in = S_DONE;
            else state_in = S_DFETCH;
         end
         S_DFETCH: begin
            if (BOUND_W'(div_k) >= bound_q || div_k >= count_found) state_in = S_DONE;
            else state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_fetch = 1'b1; state_in = S_DCHECK;
         end
         S_DCHECK: begin
            if (div_p > bound_q) state_in = S_DONE;
            else begin
               cmd.div_start = 1'b1; state_in = S_DREM;
            end
         end
         S_DREM: begin
            if (stat.rem_done) begin
               if (rem_zero) begin
                  flag_in = 1'b1; state_in = S_DONE;
               end else if (psq > 34'(value_q)) state_in = S_DONE;
               else state_in = S_DFETCH;
            end else cmd.div_iter = 1'b1;
         end
         S_DONE: begin
            valid_in = 1'b1; state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      flag_ff <= flag_in; idx_ff <= idx_in; st_ff <= st_in;
   end

   assign res_valid  = valid_ff;
   assign res_flag   = flag_ff;
   assign res_index  = idx_ff;
   assign res_status = st_ff;
endmodule
